FILE: design/dhss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhss_pkg
// Types, command codes, register indexes and the half-step coil table shared
// by the dual half-step stepper homing driver.
// ----------------------------------------------------------------------------
package dhss_pkg;

  localparam int unsigned NUM_MOTORS   = 2;
  localparam int unsigned MOTOR_HOUR   = 0;
  localparam int unsigned MOTOR_MINUTE = 1;

  // Command codes carried in the input word's tuser.
  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_STEP       = 3'd1,
    KIND_START_MOVE = 3'd2,
    KIND_START_SPIN = 3'd3,
    KIND_STOP_SPIN  = 3'd4,
    KIND_START_HOME = 3'd5
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_HOUR_SPIN_PERIOD   = 3'd0,
    REG_MINUTE_SPIN_PERIOD = 3'd1,
    REG_MINUTE_HOME_PERIOD = 3'd2,
    REG_HOUR_HOME_PERIOD   = 3'd3,
    REG_MINUTE_HOME_LIMIT  = 3'd4,
    REG_HOUR_HOME_LIMIT    = 3'd5
  } reg_index_t;

  localparam logic [15:0] HOUR_SPIN_PERIOD_RST   = 16'd20;
  localparam logic [15:0] MINUTE_SPIN_PERIOD_RST = 16'd20;
  localparam logic [7:0]  MINUTE_HOME_PERIOD_RST = 8'd20;
  localparam logic [7:0]  HOUR_HOME_PERIOD_RST   = 8'd30;
  localparam logic [11:0] MINUTE_HOME_LIMIT_RST  = 12'd2000;
  localparam logic [11:0] HOUR_HOME_LIMIT_RST    = 12'd3000;

  localparam logic [2:0] PHASE_FIRST = 3'd0;
  localparam logic [2:0] PHASE_LAST  = 3'd7;

  // Complete state of one motor, including its coil nibble.
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] steps_done;
    logic [15:0] steps_goal;
    logic        busy;
    logic        dir;
    logic        spin;
    logic [15:0] position;
    logic [15:0] spin_timer;
    logic        home;
    logic [11:0] home_steps;
    logic [7:0]  home_timer;
    logic [3:0]  nibble;
  } motor_t;

  // Reset state of one motor; only the direction differs between motors.
  function automatic motor_t motor_rst(input logic dir);
    motor_t r;
    r     = '0;
    r.dir = dir;
    return r;
  endfunction

  // Eight-beat half-step coil pattern.
  function automatic logic [3:0] beat(input logic [2:0] p);
    logic [3:0] pat;
    case (p)
      3'd0:    pat = 4'h8;
      3'd1:    pat = 4'hC;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'h3;
      3'd6:    pat = 4'h1;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  // One step of a move or a spin. A finished fixed move drops busy and
  // releases the coils instead of stepping.
  function automatic motor_t step_motor(input motor_t s);
    motor_t r;
    r = s;
    if (s.busy) begin
      if (!s.spin && (s.steps_done >= s.steps_goal)) begin
        r.busy   = 1'b0;
        r.nibble = 4'h0;
      end else begin
        r.phase      = s.dir ? s.phase - 3'd1 : s.phase + 3'd1;
        r.nibble     = beat(s.phase);
        r.steps_done = s.steps_done + 16'd1;
        if (s.spin) begin
          r.position = s.dir ? s.position - 16'd1 : s.position + 16'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: design/dual_half_step_stepper_homing_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_half_step_stepper_homing_driver
// Two-motor half-step stepper driver with timed spin and Hall-sensor homing.
//
// Each accepted command or tick word is applied to the motor state in the
// cycle it is taken and produces one status word on the master side in the
// next cycle, so the block takes one word per clock for as long as its
// output register is empty or being drained. The rate is set by the
// combinational state update between the motor registers and the output
// register. The hour motor drives the low nibble of the coil byte and the
// minute motor the high nibble; positions are signed and wrap at 16 bits.
// Configuration writes are always accepted and should be made while no
// word is in flight.
// ----------------------------------------------------------------------------
module dual_half_step_stepper_homing_driver (
  input  logic        clk,
  input  logic        rst,
  // Command words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // move_steps[15:0], reverse, minute_hall, hour_hall, pad
  input  logic [3:0]  s_axis_tuser,  // kind[2:0], motor_sel
  // Status words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // coil_port[7:0], hour_busy, minute_busy,
                                     // hour_position[15:0], minute_position[15:0],
                                     // hour_homing, minute_homing, pad
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] hour_spin_period;
  logic [15:0] minute_spin_period;
  logic [7:0]  minute_home_period;
  logic [7:0]  hour_home_period;
  logic [11:0] minute_home_limit;
  logic [11:0] hour_home_limit;

  dhss_pkg::motor_t mot      [dhss_pkg::NUM_MOTORS];
  dhss_pkg::motor_t mot_next [dhss_pkg::NUM_MOTORS];
  logic [16:0]      spin_t   [dhss_pkg::NUM_MOTORS];
  logic [8:0]       home_t   [dhss_pkg::NUM_MOTORS];

  logic        in_fire;
  logic [2:0]  kind;
  logic        motor_sel;
  logic [15:0] move_steps;
  logic        reverse;
  logic        minute_hall;
  logic        hour_hall;

  assign kind        = s_axis_tuser[2:0];
  assign motor_sel   = s_axis_tuser[3];
  assign move_steps  = s_axis_tdata[15:0];
  assign reverse     = s_axis_tdata[16];
  assign minute_hall = s_axis_tdata[17];
  assign hour_hall   = s_axis_tdata[18];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_spin_period   <= dhss_pkg::HOUR_SPIN_PERIOD_RST;
      minute_spin_period <= dhss_pkg::MINUTE_SPIN_PERIOD_RST;
      minute_home_period <= dhss_pkg::MINUTE_HOME_PERIOD_RST;
      hour_home_period   <= dhss_pkg::HOUR_HOME_PERIOD_RST;
      minute_home_limit  <= dhss_pkg::MINUTE_HOME_LIMIT_RST;
      hour_home_limit    <= dhss_pkg::HOUR_HOME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dhss_pkg::REG_HOUR_SPIN_PERIOD:   hour_spin_period   <= cfg_data;
        dhss_pkg::REG_MINUTE_SPIN_PERIOD: minute_spin_period <= cfg_data;
        dhss_pkg::REG_MINUTE_HOME_PERIOD: minute_home_period <= cfg_data[7:0];
        dhss_pkg::REG_HOUR_HOME_PERIOD:   hour_home_period   <= cfg_data[7:0];
        dhss_pkg::REG_MINUTE_HOME_LIMIT:  minute_home_limit  <= cfg_data[11:0];
        dhss_pkg::REG_HOUR_HOME_LIMIT:    hour_home_limit    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Per-motor update. A spinning motor is always busy, so on a tick the spin
  // path and the homing path never both apply to the same motor.
  always_comb begin
    for (int m = 0; m < dhss_pkg::NUM_MOTORS; m++) begin
      mot_next[m] = mot[m];
      spin_t[m]   = {1'b0, mot[m].spin_timer} + 17'd1;
      home_t[m]   = {1'b0, mot[m].home_timer} + 9'd1;

      unique case (kind)
        dhss_pkg::KIND_TICK: begin
          if (mot[m].spin) begin
            if (spin_t[m] >= {1'b0, (m == dhss_pkg::MOTOR_HOUR) ? hour_spin_period
                                                                : minute_spin_period}) begin
              mot_next[m]            = dhss_pkg::step_motor(mot[m]);
              mot_next[m].spin_timer = 16'd0;
            end else begin
              mot_next[m].spin_timer = spin_t[m][15:0];
            end
          end else if (mot[m].home && !mot[m].busy) begin
            if (m == dhss_pkg::MOTOR_MINUTE) begin
              // Minute search: every period, check the sensor, then step forward.
              if (home_t[m] < {1'b0, minute_home_period}) begin
                mot_next[m].home_timer = home_t[m][7:0];
              end else begin
                mot_next[m].home_timer = 8'd0;
                if (!minute_hall || (mot[m].home_steps >= minute_home_limit)) begin
                  mot_next[m].home       = 1'b0;
                  mot_next[m].home_steps = 12'd0;
                  mot_next[m].nibble     = 4'h0;
                end else begin
                  mot_next[m].phase      = mot[m].phase + 3'd1;
                  mot_next[m].nibble     = dhss_pkg::beat(mot[m].phase + 3'd1);
                  mot_next[m].home_steps = mot[m].home_steps + 12'd1;
                  mot_next[m].position   = mot[m].position + 16'd1;
                end
              end
            end else begin
              // Hour search: the sensor is checked on every tick and finding
              // zero also clears the offset; steps go in reverse each period.
              if (!hour_hall) begin
                mot_next[m].home       = 1'b0;
                mot_next[m].home_steps = 12'd0;
                mot_next[m].nibble     = 4'h0;
                mot_next[m].position   = 16'd0;
                mot_next[m].home_timer = 8'd0;
              end else if (home_t[m] < {1'b0, hour_home_period}) begin
                mot_next[m].home_timer = home_t[m][7:0];
              end else begin
                mot_next[m].home_timer = 8'd0;
                if (mot[m].home_steps < hour_home_limit) begin
                  mot_next[m].phase      = mot[m].phase - 3'd1;
                  mot_next[m].nibble     = dhss_pkg::beat(mot[m].phase - 3'd1);
                  mot_next[m].home_steps = mot[m].home_steps + 12'd1;
                  mot_next[m].position   = mot[m].position - 16'd1;
                end else begin
                  mot_next[m].home       = 1'b0;
                  mot_next[m].home_steps = 12'd0;
                  mot_next[m].nibble     = 4'h0;
                end
              end
            end
          end
        end
        dhss_pkg::KIND_STEP: begin
          if (motor_sel == m[0]) begin
            mot_next[m] = dhss_pkg::step_motor(mot[m]);
          end
        end
        dhss_pkg::KIND_START_MOVE: begin
          if ((motor_sel == m[0]) && !(mot[m].busy && !mot[m].spin)) begin
            mot_next[m].steps_goal = move_steps;
            mot_next[m].steps_done = 16'd0;
            mot_next[m].busy       = 1'b1;
            mot_next[m].dir        = reverse;
            mot_next[m].phase      = reverse ? dhss_pkg::PHASE_LAST : dhss_pkg::PHASE_FIRST;
          end
        end
        dhss_pkg::KIND_START_SPIN: begin
          if ((motor_sel == m[0]) && !(mot[m].spin && (mot[m].dir == reverse))) begin
            mot_next[m].spin       = 1'b1;
            mot_next[m].dir        = reverse;
            mot_next[m].busy       = 1'b1;
            mot_next[m].phase      = reverse ? dhss_pkg::PHASE_LAST : dhss_pkg::PHASE_FIRST;
            mot_next[m].spin_timer = 16'd0;
          end
        end
        dhss_pkg::KIND_STOP_SPIN: begin
          if ((motor_sel == m[0]) && mot[m].spin) begin
            mot_next[m].spin   = 1'b0;
            mot_next[m].busy   = 1'b0;
            mot_next[m].nibble = 4'h0;
          end
        end
        dhss_pkg::KIND_START_HOME: begin
          if (motor_sel == m[0]) begin
            mot_next[m].home       = 1'b1;
            mot_next[m].home_steps = 12'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < dhss_pkg::NUM_MOTORS; m++) begin
        mot[m] <= dhss_pkg::motor_rst(m == dhss_pkg::MOTOR_HOUR);
      end
    end else if (in_fire) begin
      for (int m = 0; m < dhss_pkg::NUM_MOTORS; m++) begin
        mot[m] <= mot_next[m];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {4'h0,
                       mot_next[dhss_pkg::MOTOR_MINUTE].home,
                       mot_next[dhss_pkg::MOTOR_HOUR].home,
                       mot_next[dhss_pkg::MOTOR_MINUTE].position,
                       mot_next[dhss_pkg::MOTOR_HOUR].position,
                       mot_next[dhss_pkg::MOTOR_MINUTE].busy,
                       mot_next[dhss_pkg::MOTOR_HOUR].busy,
                       mot_next[dhss_pkg::MOTOR_MINUTE].nibble,
                       mot_next[dhss_pkg::MOTOR_HOUR].nibble};
    end
  end

  // A spinning motor must always be marked busy.
  a_hour_spin_busy: assert property (@(posedge clk) disable iff (rst)
    mot[dhss_pkg::MOTOR_HOUR].spin |-> mot[dhss_pkg::MOTOR_HOUR].busy)
    else $error("hour motor spinning while not busy");

  a_minute_spin_busy: assert property (@(posedge clk) disable iff (rst)
    mot[dhss_pkg::MOTOR_MINUTE].spin |-> mot[dhss_pkg::MOTOR_MINUTE].busy)
    else $error("minute motor spinning while not busy");

  // Every accepted word leaves a status word pending in the next cycle.
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_axis_tvalid)
    else $error("accepted word produced no status word");

  // Motor state only moves when a word is accepted.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(mot[dhss_pkg::MOTOR_HOUR].position) &&
                  $stable(mot[dhss_pkg::MOTOR_MINUTE].position)))
    else $error("motor position changed without an accepted word");

endmodule
